// ===== hdl/xkd_pkg.sv =====
// shared types, pattern constants and helper functions for the keyword detector
`default_nettype none

package xkd_pkg;

    localparam int WIN_DEPTH   = 13;
    localparam int PAT_COUNT   = 11;
    localparam int PAT_MAX_LEN = WIN_DEPTH + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [WIN_DEPTH-1:0][7:0]   window_t;
    typedef logic [PAT_MAX_LEN-1:0][7:0] ctx_t;
    typedef logic [PAT_MAX_LEN*8-1:0]    pat_text_t;
    typedef logic [3:0]                  pat_len_t;

    // per-word hit summary handed from front to back
    typedef struct packed {
        logic hit;
        logic last;
    } xkd_word_t;

    // last character of each pattern sits in byte 0
    localparam pat_text_t PAT_TEXT [PAT_COUNT] = '{
        pat_text_t'("<script"),
        pat_text_t'("onerror="),
        pat_text_t'("onload="),
        pat_text_t'("onclick="),
        pat_text_t'("onmouseover="),
        pat_text_t'("onfocus="),
        pat_text_t'("onblur="),
        pat_text_t'("onsubmit="),
        pat_text_t'("onkeydown="),
        pat_text_t'("javascript:"),
        pat_text_t'("data:text/html")
    };

    localparam pat_len_t PAT_LEN [PAT_COUNT] = '{
        4'd7, 4'd8, 4'd7, 4'd8, 4'd12, 4'd8, 4'd7, 4'd9, 4'd10, 4'd11, 4'd14
    };

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic hit_any(input logic [7:0] cur, input window_t win);
        ctx_t ctx;
        logic any;
        logic ok;
        any = 1'b0;
        ctx = {win, cur};
        for (int p = 0; p < PAT_COUNT; p++)
        begin
            ok = 1'b1;
            for (int k = 0; k < PAT_MAX_LEN; k++)
            begin
                if (k < int'(PAT_LEN[p]) && ctx[k] != PAT_TEXT[p][k*8 +: 8])
                begin
                    ok = 1'b0;
                end
            end
            any = any | ok;
        end
        return any;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/xkd_front.sv =====
// front end: case folding, byte window and parallel pattern compare
`default_nettype none

module xkd_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    input  wire logic              q_full,
    output      logic              q_push,
    output      xkd_pkg::xkd_word_t q_word
);

    xkd_pkg::window_t win_reg;
    xkd_pkg::window_t win_next;
    logic [7:0]       cur;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign cur      = xkd_pkg::fold_lower(in_byte);

    always_comb
    begin
        q_word.hit  = xkd_pkg::hit_any(cur, win_reg);
        q_word.last = in_last;
        win_next    = win_reg;
        if (q_push)
        begin
            if (in_last)
            begin
                win_next = '0;
            end
            else
            begin
                win_next = {win_reg[xkd_pkg::WIN_DEPTH-2:0], cur};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/xkd_queue.sv =====
// short fifo of per-word hit summaries between front and back
`default_nettype none

module xkd_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire xkd_pkg::xkd_word_t push_word,
    output      logic               full,
    output      logic               not_empty,
    input  wire logic               pop,
    output      xkd_pkg::xkd_word_t pop_word
);

    xkd_pkg::xkd_word_t                mem_reg [xkd_pkg::QUEUE_DEPTH];
    logic [xkd_pkg::QUEUE_AW-1:0]      wr_ptr_reg;
    logic [xkd_pkg::QUEUE_AW-1:0]      rd_ptr_reg;
    logic [xkd_pkg::QUEUE_CW-1:0]      count_reg;
    logic [xkd_pkg::QUEUE_CW-1:0]      count_next;

    assign full      = count_reg == xkd_pkg::QUEUE_CW'(xkd_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/xkd_back.sv =====
// back end: sticky hit flag per string and result output register
`default_nettype none

module xkd_back
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_not_empty,
    input  wire xkd_pkg::xkd_word_t q_word,
    output      logic               q_pop,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic               out_found
);

    logic sticky_reg;
    logic sticky_next;
    logic valid_reg;
    logic valid_next;
    logic found_reg;
    logic found_next;
    logic slot_free;

    assign slot_free = !valid_reg || out_ready;
    assign q_pop     = q_not_empty && (!q_word.last || slot_free);
    assign out_valid = valid_reg;
    assign out_found = found_reg;

    always_comb
    begin
        sticky_next = sticky_reg;
        valid_next  = valid_reg && !out_ready;
        found_next  = found_reg;
        if (q_pop)
        begin
            if (q_word.last)
            begin
                valid_next  = 1'b1;
                found_next  = sticky_reg || q_word.hit;
                sticky_next = 1'b0;
            end
            else
            begin
                sticky_next = sticky_reg || q_word.hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticky_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            sticky_reg <= sticky_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
    end

endmodule

`default_nettype wire

// ===== hdl/xss_keyword_detector_unit.sv =====
// top level of the case-insensitive script keyword detector
//
// channel   dir  fields
// s_axis    in   tdata[7:0] = data_byte, tlast = end_of_string
// m_axis    out  tdata[0] = xss_found, tdata[7:1] = 0; one word per string
//
// one byte per clock while the queue is not full; the compare of all patterns against the window is combinational
// the hit summary of a string's final byte is written to the queue, and its result then to the output register
// a four-entry queue separates compare and result stages, so either side can stall
// reset clears the window, queue, sticky flag and output valid
`default_nettype none

module xss_keyword_detector_unit
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output      logic       s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // data_byte
    input  wire logic       s_axis_tlast,
    output      logic       m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output      logic [7:0] m_axis_tdata    // xss_found, zero fill
);

    xkd_pkg::xkd_word_t push_word;
    xkd_pkg::xkd_word_t pop_word;
    logic               push;
    logic               pop;
    logic               full;
    logic               not_empty;
    logic               found;

    xkd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_word   (push_word)
    );

    xkd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .not_empty (not_empty),
        .pop       (pop),
        .pop_word  (pop_word)
    );

    xkd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (not_empty),
        .q_word      (pop_word),
        .q_pop       (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_found   (found)
    );

    assign m_axis_tdata = {7'd0, found};

endmodule

`default_nettype wire
